@@ rtl/lgms_pkg.sv @@
// Shared widths, register indexes, reset values and types of the lattice gas swap engine.
package lgms_pkg;

    localparam int COORD_W   = 7;
    localparam int FPICK_W   = 11;
    localparam int EPICK_W   = 14;
    localparam int DRAW_W    = 16;
    localparam int THR_W     = 17;
    localparam int DELTA_W   = 4;
    localparam int CFG_IDX_W = 3;
    localparam int THR_COUNT = 5;

    localparam logic [CFG_IDX_W-1:0] REG_THR_D1 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THR_D2 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_THR_D3 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_THR_D4 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_THR_D5 = 3'd4;

    localparam logic [THR_W-1:0] THR_D1_RST = 17'd5379;
    localparam logic [THR_W-1:0] THR_D2_RST = 17'd442;
    localparam logic [THR_W-1:0] THR_D3_RST = 17'd36;
    localparam logic [THR_W-1:0] THR_D4_RST = 17'd3;
    localparam logic [THR_W-1:0] THR_D5_RST = 17'd0;

    typedef logic [THR_W-1:0] thr_t;

    typedef struct packed {
        logic [2:0] nbrs;
        logic       wall;
    } site_t;

endpackage

@@ rtl/lgms_ram.sv @@
// Generic synchronous RAM: one write port, two registered read ports.
module lgms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr_a,
    output logic [WIDTH-1:0] rdata_a,
    input  logic [AW-1:0]    raddr_b,
    output logic [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_a_reg;
    logic [WIDTH-1:0] rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_a_reg <= mem[raddr_a];
        rd_b_reg <= mem[raddr_b];
    end

    assign rdata_a = rd_a_reg;
    assign rdata_b = rd_b_reg;

endmodule

@@ rtl/lgms_site.sv @@
// Occupied neighbour count and wall flag of one lattice site from three row words.
module lgms_site #(
    parameter int SIDE = 100,
    localparam int AW = $clog2(SIDE)
) (
    input  logic [AW-1:0]   row,
    input  logic [AW-1:0]   col,
    input  logic [SIDE-1:0] mid,
    input  logic [SIDE-1:0] up,
    input  logic [SIDE-1:0] dn,
    input  logic            skip_en,
    input  logic [AW-1:0]   skip_row,
    input  logic [AW-1:0]   skip_col,
    output lgms_pkg::site_t site
);

    localparam logic [AW-1:0] LAST = AW'(SIDE - 1);

    logic [AW-1:0] col_r;
    logic [AW-1:0] col_l;
    logic [AW-1:0] row_u;
    logic [AW-1:0] row_d;
    logic          has_up;
    logic          has_dn;
    logic          bit_r;
    logic          bit_l;
    logic          bit_u;
    logic          bit_d;

    assign col_r  = (col == LAST) ? '0 : col + 1'b1;
    assign col_l  = (col == '0) ? LAST : col - 1'b1;
    assign row_u  = row - 1'b1;
    assign row_d  = row + 1'b1;
    assign has_up = (row != '0);
    assign has_dn = (row != LAST);

    // drop the vacated site from the count
    assign bit_r = mid[col_r] & ~(skip_en && skip_row == row && skip_col == col_r);
    assign bit_l = mid[col_l] & ~(skip_en && skip_row == row && skip_col == col_l);
    assign bit_u = has_up & up[col] & ~(skip_en && skip_row == row_u && skip_col == col);
    assign bit_d = has_dn & dn[col] & ~(skip_en && skip_row == row_d && skip_col == col);

    assign site.nbrs = 3'(bit_r) + 3'(bit_l) + 3'(bit_u) + 3'(bit_d);
    assign site.wall = ~has_up | ~has_dn;

endmodule

@@ rtl/lattice_gas_metropolis_swap.sv @@
// Top level of the lattice gas Metropolis swap engine: sequencer, lists, lattice and registers.
//
//  channel  | handshake              | payload
//  ---------+------------------------+-----------------------------------------------
//  in       | in_valid / in_stall    | filled_pick, empty_pick, uniform_draw
//  out      | out_valid / out_stall  | accepted, from_row, from_col, to_row, to_col,
//           |                        | energy_change
//  cfg      | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// A request takes one list read, three paired row reads of the lattice memory and, when kept,
// two write-backs over one write port; an out-of-range request skips the row reads.
// After reset the lattice and lists are filled by a sweep over all LATTICE_SIDE*LATTICE_SIDE
// sites; in_stall stays high during it, configuration writes are taken.
// A finished result waits in the output register; the next request is taken meanwhile and
// holds in its evaluate step only while that register is still stalled.
module lattice_gas_metropolis_swap #(
    parameter int LATTICE_SIDE = 100,
    parameter int DROPLET_HALF = 20
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [lgms_pkg::FPICK_W-1:0]        filled_pick,
    input  logic [lgms_pkg::EPICK_W-1:0]        empty_pick,
    input  logic [lgms_pkg::DRAW_W-1:0]         uniform_draw,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                accepted,
    output logic [lgms_pkg::COORD_W-1:0]        from_row,
    output logic [lgms_pkg::COORD_W-1:0]        from_col,
    output logic [lgms_pkg::COORD_W-1:0]        to_row,
    output logic [lgms_pkg::COORD_W-1:0]        to_col,
    output logic signed [lgms_pkg::DELTA_W-1:0] energy_change,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lgms_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [lgms_pkg::THR_W-1:0]          cfg_data
);

    localparam int SIDE_W     = $clog2(LATTICE_SIDE);
    localparam int CELLS      = LATTICE_SIDE * LATTICE_SIDE;
    localparam int LIST_AW    = $clog2(CELLS);
    localparam int ENTRY_W    = 2 * SIDE_W;
    localparam int ROW_LO_RAW = LATTICE_SIDE - 2 * DROPLET_HALF;
    localparam int ROW_LO     = (ROW_LO_RAW < 0) ? 0 : ROW_LO_RAW;
    localparam int COL_LO_RAW = LATTICE_SIDE / 2 - DROPLET_HALF;
    localparam int COL_LO     = (COL_LO_RAW < 0) ? 0 : COL_LO_RAW;
    localparam int COL_HI_RAW = LATTICE_SIDE / 2 + DROPLET_HALF;
    localparam int COL_HI     = (COL_HI_RAW > LATTICE_SIDE) ? LATTICE_SIDE : COL_HI_RAW;
    localparam int PARTICLES  = (LATTICE_SIDE - ROW_LO) * (COL_HI - COL_LO);
    localparam int VACANCIES  = CELLS - PARTICLES;
    localparam logic [SIDE_W-1:0] LAST = SIDE_W'(LATTICE_SIDE - 1);

    localparam logic [2:0] S_INIT = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_LIST = 3'd2;
    localparam logic [2:0] S_ROWF = 3'd3;
    localparam logic [2:0] S_ROWT = 3'd4;
    localparam logic [2:0] S_EVAL = 3'd5;
    localparam logic [2:0] S_WRB  = 3'd6;

    logic [2:0]               state_reg;
    logic [2:0]               state_next;
    logic [SIDE_W-1:0]        init_row_reg;
    logic [SIDE_W-1:0]        init_row_next;
    logic [SIDE_W-1:0]        init_col_reg;
    logic [SIDE_W-1:0]        init_col_next;
    logic [LIST_AW-1:0]       fill_ptr_reg;
    logic [LIST_AW-1:0]       fill_ptr_next;
    logic [LIST_AW-1:0]       vac_ptr_reg;
    logic [LIST_AW-1:0]       vac_ptr_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    lgms_pkg::thr_t           thr_reg [lgms_pkg::THR_COUNT];

    logic                     ok_reg;
    logic [LIST_AW-1:0]       fill_addr_reg;
    logic [LIST_AW-1:0]       vac_addr_reg;
    logic [lgms_pkg::DRAW_W-1:0] draw_reg;
    logic [ENTRY_W-1:0]       from_reg;
    logic [ENTRY_W-1:0]       to_reg;
    logic [LATTICE_SIDE-1:0]  row_from_reg;
    logic [LATTICE_SIDE-1:0]  row_to_reg;
    logic [LATTICE_SIDE-1:0]  up_from_reg;
    logic [LATTICE_SIDE-1:0]  dn_from_reg;

    logic                                accepted_reg;
    logic [lgms_pkg::COORD_W-1:0]        from_row_reg;
    logic [lgms_pkg::COORD_W-1:0]        from_col_reg;
    logic [lgms_pkg::COORD_W-1:0]        to_row_reg;
    logic [lgms_pkg::COORD_W-1:0]        to_col_reg;
    logic signed [lgms_pkg::DELTA_W-1:0] delta_reg;

    logic                     list_we;
    logic [LIST_AW-1:0]       list_waddr;
    logic [ENTRY_W-1:0]       list_wdata;
    logic [LIST_AW-1:0]       list_ra;
    logic [LIST_AW-1:0]       list_rb;
    logic [ENTRY_W-1:0]       list_da;
    logic [ENTRY_W-1:0]       list_db;

    logic                     occ_we;
    logic [SIDE_W-1:0]        occ_waddr;
    logic [LATTICE_SIDE-1:0]  occ_wdata;
    logic [SIDE_W-1:0]        occ_ra;
    logic [SIDE_W-1:0]        occ_rb;
    logic [LATTICE_SIDE-1:0]  occ_da;
    logic [LATTICE_SIDE-1:0]  occ_db;

    logic [LATTICE_SIDE-1:0]  drop_mask;
    logic [LATTICE_SIDE-1:0]  bit_fc;
    logic [LATTICE_SIDE-1:0]  bit_tc;
    logic [LATTICE_SIDE-1:0]  word_from_new;
    logic [LATTICE_SIDE-1:0]  word_to_new;
    logic                     init_row_in;
    logic                     init_in;
    logic                     init_last;
    logic                     in_take;
    logic                     pick_ok;
    logic                     out_free;
    logic                     same_row;
    logic [SIDE_W-1:0]        fr;
    logic [SIDE_W-1:0]        fc;
    logic [SIDE_W-1:0]        tr;
    logic [SIDE_W-1:0]        tc;
    logic [SIDE_W-1:0]        fr_up;
    logic [SIDE_W-1:0]        fr_dn;
    logic [SIDE_W-1:0]        tr_up;
    logic [SIDE_W-1:0]        tr_dn;
    lgms_pkg::site_t          site_old;
    lgms_pkg::site_t          site_new;
    logic [3:0]               mag_old;
    logic [3:0]               mag_new;
    logic signed [lgms_pkg::DELTA_W-1:0] delta;
    lgms_pkg::thr_t           thr_sel;
    logic                     keep;

    always_comb
    begin
        for (int j = 0; j < LATTICE_SIDE; j++)
        begin
            drop_mask[j] = (j >= COL_LO) && (j < COL_HI);
        end
    end

    assign init_row_in = int'(init_row_reg) >= ROW_LO;
    assign init_in     = init_row_in && (int'(init_col_reg) >= COL_LO)
                         && (int'(init_col_reg) < COL_HI);
    assign init_last   = (init_row_reg == LAST) && (init_col_reg == LAST);

    assign in_stall = (state_reg != S_IDLE);
    assign in_take  = in_valid && !in_stall;
    assign pick_ok  = (int'(filled_pick) < PARTICLES) && (int'(empty_pick) < VACANCIES);
    assign out_free = !out_valid_reg || !out_stall;

    assign fr = from_reg[ENTRY_W-1:SIDE_W];
    assign fc = from_reg[SIDE_W-1:0];
    assign tr = to_reg[ENTRY_W-1:SIDE_W];
    assign tc = to_reg[SIDE_W-1:0];
    assign fr_up = (fr == '0) ? fr : fr - 1'b1;
    assign fr_dn = (fr == LAST) ? fr : fr + 1'b1;
    assign tr_up = (tr == '0) ? tr : tr - 1'b1;
    assign tr_dn = (tr == LAST) ? tr : tr + 1'b1;
    assign same_row = (fr == tr);

    assign bit_fc = {{(LATTICE_SIDE-1){1'b0}}, 1'b1} << fc;
    assign bit_tc = {{(LATTICE_SIDE-1){1'b0}}, 1'b1} << tc;
    assign word_from_new = (row_from_reg & ~bit_fc) | (same_row ? bit_tc : '0);
    assign word_to_new   = (row_to_reg | bit_tc) & ~(same_row ? bit_fc : '0);

    lgms_site #(
        .SIDE     (LATTICE_SIDE)
    ) u_site_old (
        .row      (fr),
        .col      (fc),
        .mid      (row_from_reg),
        .up       (up_from_reg),
        .dn       (dn_from_reg),
        .skip_en  (1'b0),
        .skip_row (fr),
        .skip_col (fc),
        .site     (site_old)
    );

    lgms_site #(
        .SIDE     (LATTICE_SIDE)
    ) u_site_new (
        .row      (tr),
        .col      (tc),
        .mid      (row_to_reg),
        .up       (occ_da),
        .dn       (occ_db),
        .skip_en  (1'b1),
        .skip_row (fr),
        .skip_col (fc),
        .site     (site_new)
    );

    assign mag_old = {1'b0, site_old.nbrs} + {2'b00, site_old.wall, 1'b0};
    assign mag_new = {1'b0, site_new.nbrs} + {2'b00, site_new.wall, 1'b0};
    assign delta   = $signed(mag_old - mag_new);

    always_comb
    begin
        unique case (delta)
            4'sd1:   thr_sel = thr_reg[0];
            4'sd2:   thr_sel = thr_reg[1];
            4'sd3:   thr_sel = thr_reg[2];
            4'sd4:   thr_sel = thr_reg[3];
            4'sd5:   thr_sel = thr_reg[4];
            default: thr_sel = '0;
        endcase
    end

    assign keep = delta[lgms_pkg::DELTA_W-1] || (delta == '0)
                  || ({1'b0, draw_reg} < thr_sel);

    // list reads are addressed straight from the request
    assign list_ra = LIST_AW'(filled_pick);
    assign list_rb = LIST_AW'(PARTICLES) + LIST_AW'(empty_pick);

    always_comb
    begin
        case (state_reg)
            S_LIST:
            begin
                occ_ra = list_da[ENTRY_W-1:SIDE_W];
                occ_rb = list_db[ENTRY_W-1:SIDE_W];
            end
            S_ROWF:
            begin
                occ_ra = fr_up;
                occ_rb = fr_dn;
            end
            default:
            begin
                occ_ra = tr_up;
                occ_rb = tr_dn;
            end
        endcase
    end

    always_comb
    begin
        list_we    = 1'b0;
        list_waddr = fill_addr_reg;
        list_wdata = to_reg;
        occ_we     = 1'b0;
        occ_waddr  = fr;
        occ_wdata  = word_from_new;
        case (state_reg)
            S_INIT:
            begin
                list_we    = 1'b1;
                list_waddr = init_in ? fill_ptr_reg : vac_ptr_reg;
                list_wdata = {init_row_reg, init_col_reg};
                occ_we     = 1'b1;
                occ_waddr  = init_row_reg;
                occ_wdata  = init_row_in ? drop_mask : '0;
            end
            S_EVAL:
            begin
                list_we = out_free && ok_reg && keep;
                occ_we  = out_free && ok_reg && keep;
            end
            S_WRB:
            begin
                list_we    = 1'b1;
                list_waddr = vac_addr_reg;
                list_wdata = from_reg;
                occ_we     = 1'b1;
                occ_waddr  = tr;
                occ_wdata  = word_to_new;
            end
            default:
            begin
                list_we = 1'b0;
            end
        endcase
    end

    lgms_ram #(
        .WIDTH   (ENTRY_W),
        .DEPTH   (CELLS)
    ) u_list_ram (
        .clk     (clk),
        .we      (list_we),
        .waddr   (list_waddr),
        .wdata   (list_wdata),
        .raddr_a (list_ra),
        .rdata_a (list_da),
        .raddr_b (list_rb),
        .rdata_b (list_db)
    );

    lgms_ram #(
        .WIDTH   (LATTICE_SIDE),
        .DEPTH   (LATTICE_SIDE)
    ) u_occ_ram (
        .clk     (clk),
        .we      (occ_we),
        .waddr   (occ_waddr),
        .wdata   (occ_wdata),
        .raddr_a (occ_ra),
        .rdata_a (occ_da),
        .raddr_b (occ_rb),
        .rdata_b (occ_db)
    );

    // write-backs finish before the next request is taken, so no access overlaps an entry
    always_comb
    begin
        state_next     = state_reg;
        init_row_next  = init_row_reg;
        init_col_next  = init_col_reg;
        fill_ptr_next  = fill_ptr_reg;
        vac_ptr_next   = vac_ptr_reg;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            S_INIT:
            begin
                if (init_in)
                begin
                    fill_ptr_next = fill_ptr_reg + 1'b1;
                end
                else
                begin
                    vac_ptr_next = vac_ptr_reg + 1'b1;
                end
                if (init_col_reg == LAST)
                begin
                    init_col_next = '0;
                    init_row_next = init_row_reg + 1'b1;
                end
                else
                begin
                    init_col_next = init_col_reg + 1'b1;
                end
                if (init_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_take)
                begin
                    state_next = S_LIST;
                end
            end
            S_LIST:
            begin
                state_next = ok_reg ? S_ROWF : S_EVAL;
            end
            S_ROWF:
            begin
                state_next = S_ROWT;
            end
            S_ROWT:
            begin
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = (ok_reg && keep) ? S_WRB : S_IDLE;
                end
            end
            S_WRB:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            init_row_reg  <= '0;
            init_col_reg  <= '0;
            fill_ptr_reg  <= '0;
            vac_ptr_reg   <= LIST_AW'(PARTICLES);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            init_row_reg  <= init_row_next;
            init_col_reg  <= init_col_next;
            fill_ptr_reg  <= fill_ptr_next;
            vac_ptr_reg   <= vac_ptr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg[0] <= lgms_pkg::THR_D1_RST;
            thr_reg[1] <= lgms_pkg::THR_D2_RST;
            thr_reg[2] <= lgms_pkg::THR_D3_RST;
            thr_reg[3] <= lgms_pkg::THR_D4_RST;
            thr_reg[4] <= lgms_pkg::THR_D5_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                lgms_pkg::REG_THR_D1: thr_reg[0] <= cfg_data;
                lgms_pkg::REG_THR_D2: thr_reg[1] <= cfg_data;
                lgms_pkg::REG_THR_D3: thr_reg[2] <= cfg_data;
                lgms_pkg::REG_THR_D4: thr_reg[3] <= cfg_data;
                lgms_pkg::REG_THR_D5: thr_reg[4] <= cfg_data;
                default:              thr_reg[0] <= thr_reg[0];
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            ok_reg        <= pick_ok;
            fill_addr_reg <= list_ra;
            vac_addr_reg  <= list_rb;
            draw_reg      <= uniform_draw;
        end
        if (state_reg == S_LIST)
        begin
            from_reg <= list_da;
            to_reg   <= list_db;
        end
        if (state_reg == S_ROWF)
        begin
            row_from_reg <= occ_da;
            row_to_reg   <= occ_db;
        end
        if (state_reg == S_ROWT)
        begin
            up_from_reg <= occ_da;
            dn_from_reg <= occ_db;
        end
        if (state_reg == S_EVAL && out_free)
        begin
            accepted_reg <= ok_reg && keep;
            from_row_reg <= ok_reg ? lgms_pkg::COORD_W'(fr) : '0;
            from_col_reg <= ok_reg ? lgms_pkg::COORD_W'(fc) : '0;
            to_row_reg   <= ok_reg ? lgms_pkg::COORD_W'(tr) : '0;
            to_col_reg   <= ok_reg ? lgms_pkg::COORD_W'(tc) : '0;
            delta_reg    <= ok_reg ? delta : '0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign accepted      = accepted_reg;
    assign from_row      = from_row_reg;
    assign from_col      = from_col_reg;
    assign to_row        = to_row_reg;
    assign to_col        = to_col_reg;
    assign energy_change = delta_reg;

endmodule
